// File: rtl/lsre_pkg.sv
// shared constants, codes and types of the link-state route engine
package lsre_pkg;

    localparam int NODES   = 32;
    localparam int NODE_W  = $clog2(NODES);
    localparam int ADDR_W  = 2 * NODE_W;
    localparam int IFACE_W = 3;
    localparam int COST_W  = 16;
    localparam int PCOST_W = 24;
    localparam int SEQ_W   = 32;
    localparam int TTL_W   = 8;

    localparam logic [PCOST_W-1:0] COST_MAX = '1;

    localparam logic [1:0] OP_ADV    = 2'd0;
    localparam logic [1:0] OP_NUP    = 2'd1;
    localparam logic [1:0] OP_NDN    = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP  = 2'd1;
    localparam logic [1:0] KIND_NBR     = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [COST_W-1:0]  cost;
    } t_adj;

    typedef struct packed {
        logic               valid;
        logic [NODE_W-1:0]  hop;
        logic [IFACE_W-1:0] iface;
        logic [PCOST_W-1:0] cost;
    } t_route;

endpackage

// File: rtl/lsre_adj_ram.sv
// adjacency memory, one word per (origin, neighbor) pair, registered read
module lsre_adj_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [lsre_pkg::ADDR_W-1:0] i_waddr,
    input  lsre_pkg::t_adj            i_wdata,
    input  logic [lsre_pkg::ADDR_W-1:0] i_raddr,
    output lsre_pkg::t_adj            o_rdata
);
    lsre_pkg::t_adj r_mem [lsre_pkg::NODES*lsre_pkg::NODES];
    lsre_pkg::t_adj r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/lsre_spf.sv
// shortest path first unit: route table plus min scan and relax passes
module lsre_spf (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_start,
    input  logic [lsre_pkg::NODE_W-1:0]                i_own,
    input  logic [lsre_pkg::NODES-1:0]                 i_db_present,
    input  logic [lsre_pkg::NODES*lsre_pkg::IFACE_W-1:0] i_nbr_iface,
    input  logic [lsre_pkg::NODE_W-1:0]                i_lk_node,
    output logic                                       o_busy,
    output lsre_pkg::t_route                           o_lk,
    output logic [lsre_pkg::ADDR_W-1:0]                o_adj_raddr,
    input  lsre_pkg::t_adj                             i_adj
);
    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_SCAN  = 2'd1;
    localparam logic [1:0] P_PICK  = 2'd2;
    localparam logic [1:0] P_RELAX = 2'd3;

    logic [1:0]                       r_state;
    logic [lsre_pkg::NODES-1:0]       r_valid;
    logic [lsre_pkg::NODES-1:0]       r_visited;
    logic [lsre_pkg::NODE_W-1:0]      r_hop   [lsre_pkg::NODES];
    logic [lsre_pkg::IFACE_W-1:0]     r_iface [lsre_pkg::NODES];
    logic [lsre_pkg::PCOST_W-1:0]     r_cost  [lsre_pkg::NODES];
    logic [lsre_pkg::NODE_W-1:0]      r_cnt;
    logic                             r_found;
    logic [lsre_pkg::NODE_W-1:0]      r_best;
    logic [lsre_pkg::PCOST_W-1:0]     r_bcost;
    logic [lsre_pkg::NODE_W-1:0]      r_bhop;
    logic [lsre_pkg::IFACE_W-1:0]     r_biface;
    logic [lsre_pkg::NODE_W-1:0]      r_own;

    logic [lsre_pkg::NODE_W-1:0]      rd_idx;
    lsre_pkg::t_route                 cur;
    logic [lsre_pkg::PCOST_W:0]       sum;
    logic [lsre_pkg::PCOST_W-1:0]     nc;
    logic                             upd;
    logic                             cand;
    logic [lsre_pkg::NODE_W-1:0]      cnt_nx;

    // one read index: the pass counter while busy, the lookup node when idle
    assign rd_idx    = (r_state == P_IDLE) ? i_lk_node : r_cnt;
    assign cur.valid = r_valid[rd_idx];
    assign cur.hop   = r_hop[rd_idx];
    assign cur.iface = r_iface[rd_idx];
    assign cur.cost  = r_cost[rd_idx];
    assign o_lk      = cur;
    assign o_busy    = (r_state != P_IDLE);
    assign cnt_nx    = r_cnt + 1'b1;

    assign sum  = {1'b0, r_bcost} + {{(lsre_pkg::PCOST_W+1-lsre_pkg::COST_W){1'b0}}, i_adj.cost};
    assign nc   = sum[lsre_pkg::PCOST_W] ? lsre_pkg::COST_MAX : sum[lsre_pkg::PCOST_W-1:0];
    assign upd  = i_adj.valid && (!cur.valid || nc < cur.cost);
    assign cand = !r_visited[r_cnt] && cur.valid && (!r_found || cur.cost < r_bcost);

    always_comb begin
        if (r_state == P_RELAX) begin
            o_adj_raddr = {r_best, cnt_nx};
        end else begin
            o_adj_raddr = {r_best, {lsre_pkg::NODE_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= P_IDLE;
            r_valid   <= '0;
            r_visited <= '0;
            r_found   <= 1'b0;
            r_cnt     <= '0;
        end else begin
            unique case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_valid         <= lsre_pkg::NODES'(1) << i_own;
                        r_visited       <= '0;
                        r_hop[i_own]    <= i_own;
                        r_iface[i_own]  <= '0;
                        r_cost[i_own]   <= '0;
                        r_own           <= i_own;
                        r_cnt           <= '0;
                        r_found         <= 1'b0;
                        r_state         <= P_SCAN;
                    end
                end
                P_SCAN: begin
                    // strict less-than in index order keeps the lowest node on a tie
                    if (cand) begin
                        r_found  <= 1'b1;
                        r_best   <= r_cnt;
                        r_bcost  <= cur.cost;
                        r_bhop   <= cur.hop;
                        r_biface <= cur.iface;
                    end
                    r_cnt <= cnt_nx;
                    if (r_cnt == lsre_pkg::NODE_W'(lsre_pkg::NODES - 1)) begin
                        r_state <= P_PICK;
                    end
                end
                P_PICK: begin
                    r_cnt <= '0;
                    if (!r_found) begin
                        r_state <= P_IDLE;
                    end else begin
                        r_visited[r_best] <= 1'b1;
                        r_found           <= 1'b0;
                        r_state           <= i_db_present[r_best] ? P_RELAX : P_SCAN;
                    end
                end
                P_RELAX: begin
                    if (upd) begin
                        r_valid[r_cnt] <= 1'b1;
                        r_cost[r_cnt]  <= nc;
                        if (r_best == r_own) begin
                            r_hop[r_cnt]   <= r_cnt;
                            r_iface[r_cnt] <= i_nbr_iface[r_cnt*lsre_pkg::IFACE_W +: lsre_pkg::IFACE_W];
                        end else begin
                            r_hop[r_cnt]   <= r_bhop;
                            r_iface[r_cnt] <= r_biface;
                        end
                    end
                    r_cnt <= cnt_nx;
                    if (r_cnt == lsre_pkg::NODE_W'(lsre_pkg::NODES - 1)) begin
                        r_state <= P_SCAN;
                    end
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/link_state_route_engine_top.sv
// link-state route engine top: item control, database registers, result register
//
//  channel   dir  handshake                       content
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser opcode, tlast last entry, tdata fields
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tuser result kind, tdata result fields
//  cfg       in   i_cfg_we                         own node number
//
// row replace (new advertisement or first own link) adds a row clear
// spf: per settled node a min scan over all nodes, a pick state and, if its row is
//   present, a relax pass over its adjacency row, plus a closing scan per rerun
// reset clears control, database present bits, neighbor table and routes;
//   adjacency rows are cleared whenever a row becomes present, never read before
// one item at a time; a new item is taken while the previous result waits on m_axis
module link_state_route_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // node_id[4:0] seq_num[36:5] ttl_in[44:37] link_valid[45] link_nbr[50:46]
    // link_cost[66:51] iface_in[69:67], zero pad above
    input  logic [71:0] i_s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // forward_adv[0] ttl_out[8:1] send_own_adv[9] route_found[10] next_hop[15:11]
    // iface_out[18:16] path_cost[42:19], zero pad above
    output logic [47:0] o_m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]  o_m_axis_tuser
);
    localparam int NW = lsre_pkg::NODE_W;
    localparam int IW = lsre_pkg::IFACE_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_CLR  = 4'd2;
    localparam logic [3:0] S_ADV  = 4'd3;
    localparam logic [3:0] S_ADVW = 4'd4;
    localparam logic [3:0] S_ADVE = 4'd5;
    localparam logic [3:0] S_NUP  = 4'd6;
    localparam logic [3:0] S_NDN1 = 4'd7;
    localparam logic [3:0] S_NDN2 = 4'd8;
    localparam logic [3:0] S_SPF  = 4'd9;
    localparam logic [3:0] S_SPFW = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]                   r_state;
    logic [3:0]                   r_ret;
    logic [NW-1:0]                r_own;

    // captured item
    logic [1:0]                   r_op;
    logic [NW-1:0]                r_node;
    logic [lsre_pkg::SEQ_W-1:0]   r_seq;
    logic [lsre_pkg::TTL_W-1:0]   r_ttl;
    logic                         r_lv;
    logic [NW-1:0]                r_lnbr;
    logic [lsre_pkg::COST_W-1:0]  r_lcost;
    logic [IW-1:0]                r_iface;
    logic                         r_last;

    // database and neighbor table
    logic [lsre_pkg::NODES-1:0]    r_db_present;
    logic [lsre_pkg::SEQ_W-1:0]    r_db_seq [lsre_pkg::NODES];
    logic [lsre_pkg::NODES-1:0]    r_nbr_present;
    logic [lsre_pkg::NODES*IW-1:0] r_nbr_iface;

    // advertisement train
    logic                         r_adv_open;
    logic                         r_adv_acc;
    logic [NW-1:0]                r_origin;
    logic                         r_changed;

    // row clear sweep
    logic [NW-1:0]                r_row;
    logic [NW-1:0]                r_cnt;

    // result register
    logic                         r_m_valid;
    logic [47:0]                  r_m_data;
    logic [1:0]                   r_m_kind;

    logic                         accept;
    logic                         first_acc;
    logic                         nup_ok;
    logic                         ram_we;
    logic [lsre_pkg::ADDR_W-1:0]  ram_waddr;
    lsre_pkg::t_adj               ram_wdata;
    logic [lsre_pkg::ADDR_W-1:0]  ram_raddr;
    lsre_pkg::t_adj               ram_rdata;
    logic                         spf_start;
    logic                         spf_busy;
    lsre_pkg::t_route             lk;
    logic [lsre_pkg::ADDR_W-1:0]  spf_raddr;
    logic [lsre_pkg::TTL_W-1:0]   ttl_dec;
    logic [1:0]                   kind;
    logic [47:0]                  res_data;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_kind;
    assign spf_start       = (r_state == S_SPF);

    // new origin or strictly larger sequence takes the train
    assign first_acc = !r_db_present[r_node] || (r_seq > r_db_seq[r_node]);
    assign nup_ok    = (r_node != r_own) && !r_nbr_present[r_node];

    // adjacency port: spf owns the read side while busy
    assign ram_raddr = spf_busy ? spf_raddr : {r_origin, r_lnbr};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {r_row, r_cnt};
        ram_wdata = '0;
        case (r_state)
            S_CLR: ram_we = 1'b1;
            S_ADVW: begin
                // first cost named for a link stays
                ram_we    = !ram_rdata.valid;
                ram_waddr = {r_origin, r_lnbr};
                ram_wdata = {1'b1, r_lcost};
            end
            S_NUP: begin
                ram_we    = 1'b1;
                ram_waddr = {r_own, r_node};
                ram_wdata = {1'b1, lsre_pkg::COST_W'(1)};
            end
            S_NDN1: begin
                ram_we    = 1'b1;
                ram_waddr = {r_own, r_node};
            end
            S_NDN2: begin
                ram_we    = 1'b1;
                ram_waddr = {r_node, r_own};
            end
            default: ram_we = 1'b0;
        endcase
    end

    // result fields
    assign ttl_dec = (r_ttl != '0) ? (r_ttl - 1'b1) : '0;

    always_comb begin
        res_data = '0;
        unique case (r_op)
            lsre_pkg::OP_ADV: begin
                kind = lsre_pkg::KIND_VERDICT;
                res_data[0]   = r_adv_acc;
                res_data[8:1] = r_adv_acc ? ttl_dec : '0;
            end
            lsre_pkg::OP_LOOKUP: begin
                kind = lsre_pkg::KIND_LOOKUP;
                if (lk.valid) begin
                    res_data[10]    = 1'b1;
                    res_data[15:11] = lk.hop;
                    res_data[18:16] = lk.iface;
                    res_data[42:19] = lk.cost;
                end
            end
            lsre_pkg::OP_NUP, lsre_pkg::OP_NDN: begin
                kind = lsre_pkg::KIND_NBR;
                res_data[9] = r_changed;
            end
            default: kind = lsre_pkg::KIND_NBR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own <= '0;
        end else if (i_cfg_we) begin
            r_own <= i_cfg_wdata;
        end
    end

    // item capture, payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_s_axis_tuser;
            r_node  <= i_s_axis_tdata[4:0];
            r_seq   <= i_s_axis_tdata[36:5];
            r_ttl   <= i_s_axis_tdata[44:37];
            r_lv    <= i_s_axis_tdata[45];
            r_lnbr  <= i_s_axis_tdata[50:46];
            r_lcost <= i_s_axis_tdata[66:51];
            r_iface <= i_s_axis_tdata[69:67];
            r_last  <= i_s_axis_tlast;
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ret         <= S_IDLE;
            r_db_present  <= '0;
            r_nbr_present <= '0;
            r_nbr_iface   <= '0;
            r_adv_open    <= 1'b0;
            r_adv_acc     <= 1'b0;
            r_origin      <= '0;
            r_changed     <= 1'b0;
            r_cnt         <= '0;
            r_row         <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            // the output state reloads the register itself
            if (r_m_valid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_cnt <= '0;
                    unique case (r_op)
                        lsre_pkg::OP_ADV: begin
                            if (!r_adv_open) begin
                                r_adv_open <= 1'b1;
                                r_adv_acc  <= first_acc;
                                r_origin   <= r_node;
                                if (first_acc) begin
                                    r_db_present[r_node] <= 1'b1;
                                    r_db_seq[r_node]     <= r_seq;
                                    r_row                <= r_node;
                                    r_ret                <= S_ADV;
                                    r_state              <= S_CLR;
                                end else begin
                                    r_state <= S_ADV;
                                end
                            end else begin
                                r_state <= S_ADV;
                            end
                        end
                        lsre_pkg::OP_NUP: begin
                            if (nup_ok) begin
                                r_changed                       <= 1'b1;
                                r_nbr_present[r_node]           <= 1'b1;
                                r_nbr_iface[r_node*IW +: IW]    <= r_iface;
                                if (!r_db_present[r_own]) begin
                                    r_db_present[r_own] <= 1'b1;
                                    r_db_seq[r_own]     <= r_seq;
                                    r_row               <= r_own;
                                    r_ret               <= S_NUP;
                                    r_state             <= S_CLR;
                                end else begin
                                    r_state <= S_NUP;
                                end
                            end else begin
                                r_changed <= 1'b0;
                                r_state   <= S_OUT;
                            end
                        end
                        lsre_pkg::OP_NDN: begin
                            if (r_nbr_present[r_node]) begin
                                r_changed             <= 1'b1;
                                r_nbr_present[r_node] <= 1'b0;
                                r_state               <= S_NDN1;
                            end else begin
                                r_changed <= 1'b0;
                                r_state   <= S_OUT;
                            end
                        end
                        lsre_pkg::OP_LOOKUP: r_state <= S_OUT;
                        default: r_state <= S_OUT;
                    endcase
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == NW'(lsre_pkg::NODES - 1)) begin
                        r_state <= r_ret;
                    end
                end
                S_ADV: begin
                    r_state <= (r_adv_acc && r_lv) ? S_ADVW : S_ADVE;
                end
                S_ADVW: r_state <= S_ADVE;
                S_ADVE: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_adv_open <= 1'b0;
                        r_state    <= r_adv_acc ? S_SPF : S_OUT;
                    end
                end
                S_NUP:  r_state <= S_SPF;
                S_NDN1: r_state <= S_NDN2;
                S_NDN2: r_state <= S_SPF;
                S_SPF:  r_state <= S_SPFW;
                S_SPFW: begin
                    if (!spf_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= res_data;
                        r_m_kind  <= kind;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    lsre_adj_ram u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lsre_spf u_spf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (spf_start),
        .i_own        (r_own),
        .i_db_present (r_db_present),
        .i_nbr_iface  (r_nbr_iface),
        .i_lk_node    (r_node),
        .o_busy       (spf_busy),
        .o_lk         (lk),
        .o_adj_raddr  (spf_raddr),
        .i_adj        (ram_rdata)
    );
endmodule

// File: rtl/lsre_checker.sv
// port-level checks of the route engine result stream
module lsre_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == lsre_pkg::KIND_VERDICT ||
                             o_m_axis_tuser == lsre_pkg::KIND_LOOKUP ||
                             o_m_axis_tuser == lsre_pkg::KIND_NBR))
        else $error("unknown result kind");

    a_noroute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == lsre_pkg::KIND_LOOKUP && !o_m_axis_tdata[10]
        |-> o_m_axis_tdata == 48'd0)
        else $error("lookup without route carries data");

    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == lsre_pkg::KIND_VERDICT && !o_m_axis_tdata[0]
        |-> o_m_axis_tdata[8:1] == 8'd0)
        else $error("refused advertisement with nonzero ttl");

    a_sendown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != lsre_pkg::KIND_NBR |-> !o_m_axis_tdata[9])
        else $error("own advertisement flag outside neighbor result");
endmodule

bind link_state_route_engine_top lsre_checker u_lsre_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
